>>> rtl/core/dltq_pkg.sv
// Shared constants and codes of the delta-list timer queue.
package dltq_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 16;
  localparam int unsigned DELAY_BITS_DEF = 32;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_ADD_REJ  = 3'd1,
    EV_DELETED  = 3'd2,
    EV_NOT_PEND = 3'd3,
    EV_EXPIRED  = 3'd4,
    EV_RUN_DONE = 3'd5
  } event_e;

endpackage

>>> rtl/core/dltq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/delta_list_timer_queue.sv
// Delta-list timer queue: add, delete and run over a linked list held in RAMs.
// An add reads and checks each entry it examines, then links in through S_A_WR1 and
// S_A_WR2 (or appends in S_A_APP); a delete reads the slot, then its successor
// unless the slot is the tail, then writes; a run reads and checks the head until
// the list is empty or not yet due, then reports done. No new item is taken until idle.
// Reset clears the pending flags, empties the list and zeroes the last run time.
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] delay_i,
  input  logic [63:0] payload_i,
  input  logic [63:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [3:0]  out_slot_o,
  output logic [63:0] out_payload_o,
  output logic        last_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned DW = DELAY_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_A_RD, S_A_CHK, S_A_WR1, S_A_WR2, S_A_APP,
    S_D_RD, S_D_CHK, S_D_RD2, S_D_WR, S_R_RD, S_R_CHK, S_R_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  logic [SW-1:0]     head_q, head_d, tail_q, tail_d;
  logic              empty_q, empty_d;
  logic [63:0]       last_run_q, last_run_d;
  logic [SW-1:0]     s_q, s_d, cur_q, cur_d, n_q, n_d, p_q, p_d;
  logic [DW-1:0]     d_q, d_d, rel_c_q, rel_c_d;
  logic [63:0]       pay_q, pay_d, left_q, left_d;
  event_e            resp_q, resp_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_res_q, out_res_d;
  logic [3:0]        out_slot_q, out_slot_d;
  logic [63:0]       out_pay_q, out_pay_d;
  logic              out_last_q, out_last_d;

  // RAM ports; all four stores share one read address.
  logic              re;
  logic [SW-1:0]     raddr;
  logic              rel_we, pay_we, nxt_we, prv_we;
  logic [SW-1:0]     rel_wa, pay_wa, nxt_wa, prv_wa;
  logic [DW-1:0]     rel_wd, rel_rd;
  logic [63:0]       pay_rd;
  logic [SW-1:0]     nxt_wd, nxt_rd, prv_wd, prv_rd;

  logic              out_free, in_acc, slot_ok;
  logic [SW-1:0]     slot_idx;
  logic [DW:0]       sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign slot_idx = SW'(slot_i);
  assign slot_ok = (32'(slot_i) < 32'(NUM_SLOTS));
  assign sum = {1'b0, rel_rd} + {1'b0, rel_c_q};

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    last_run_d = last_run_q;
    s_d        = s_q;
    cur_d      = cur_q;
    n_d        = n_q;
    p_d        = p_q;
    d_d        = d_q;
    rel_c_d    = rel_c_q;
    pay_d      = pay_q;
    left_d     = left_q;
    resp_d     = resp_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    out_res_d  = out_res_q;
    out_slot_d = out_slot_q;
    out_pay_d  = out_pay_q;
    out_last_d = out_last_q;
    re     = 1'b0;
    raddr  = cur_q;
    rel_we = 1'b0; rel_wa = s_q; rel_wd = d_q;
    pay_we = 1'b0; pay_wa = s_q;
    nxt_we = 1'b0; nxt_wa = s_q; nxt_wd = cur_q;
    prv_we = 1'b0; prv_wa = s_q; prv_wd = p_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          s_d    = slot_idx;
          d_d    = DW'(delay_i);
          pay_d  = payload_i;
          cur_d  = head_q;
          case (kind_e'(kind_i))
            KIND_ADD: begin
              if (!slot_ok || pend_q[slot_idx]) begin
                resp_d  = EV_ADD_REJ;
                state_d = S_RESP;
              end else begin
                state_d = empty_q ? S_A_APP : S_A_RD;
              end
            end
            KIND_DEL: begin
              if (!slot_ok || !pend_q[slot_idx]) begin
                resp_d  = EV_NOT_PEND;
                state_d = S_RESP;
              end else begin
                state_d = S_D_RD;
              end
            end
            KIND_RUN: begin
              left_d     = now_i - last_run_q;
              last_run_d = now_i;
              state_d    = S_R_RD;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = resp_q;
          out_slot_d  = 4'(s_q);
          out_pay_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_A_RD: begin
        re      = 1'b1;
        raddr   = cur_q;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (d_q <= rel_rd) begin
          p_d     = prv_rd;
          rel_c_d = rel_rd - d_q;
          state_d = S_A_WR1;
        end else begin
          d_d = d_q - rel_rd;
          if (cur_q == tail_q) begin
            state_d = S_A_APP;
          end else begin
            cur_d   = nxt_rd;
            state_d = S_A_RD;
          end
        end
      end
      S_A_WR1: begin
        rel_we = 1'b1; rel_wa = cur_q; rel_wd = rel_c_q;
        nxt_we = 1'b1; nxt_wa = s_q;   nxt_wd = cur_q;
        prv_we = 1'b1; prv_wa = cur_q; prv_wd = s_q;
        state_d = S_A_WR2;
      end
      S_A_WR2: begin
        if (out_free) begin
          rel_we = 1'b1; rel_wa = s_q; rel_wd = d_q;
          prv_we = 1'b1; prv_wa = s_q; prv_wd = p_q;
          pay_we = 1'b1; pay_wa = s_q;
          if (cur_q == head_q) begin
            head_d = s_q;
          end else begin
            nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = s_q;
          end
          pend_d[s_q] = 1'b1;
          out_valid_d = 1'b1;
          out_res_d   = EV_ADDED;
          out_slot_d  = 4'(s_q);
          out_pay_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_A_APP: begin
        if (out_free) begin
          rel_we = 1'b1; rel_wa = s_q; rel_wd = d_q;
          pay_we = 1'b1; pay_wa = s_q;
          if (empty_q) begin
            head_d  = s_q;
            empty_d = 1'b0;
          end else begin
            nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = s_q;
            prv_we = 1'b1; prv_wa = s_q;    prv_wd = tail_q;
          end
          tail_d      = s_q;
          pend_d[s_q] = 1'b1;
          out_valid_d = 1'b1;
          out_res_d   = EV_ADDED;
          out_slot_d  = 4'(s_q);
          out_pay_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_D_RD: begin
        re      = 1'b1;
        raddr   = s_q;
        state_d = S_D_CHK;
      end
      S_D_CHK: begin
        rel_c_d = rel_rd;
        n_d     = nxt_rd;
        p_d     = prv_rd;
        state_d = (s_q != tail_q) ? S_D_RD2 : S_D_WR;
      end
      S_D_RD2: begin
        re      = 1'b1;
        raddr   = n_q;
        state_d = S_D_WR;
      end
      S_D_WR: begin
        if (out_free) begin
          if (s_q != tail_q) begin
            // The successor absorbs the removed delta, saturating on overflow.
            rel_we = 1'b1; rel_wa = n_q;
            rel_wd = sum[DW] ? '1 : sum[DW-1:0];
          end
          if (s_q == head_q && s_q == tail_q) begin
            empty_d = 1'b1;
          end else begin
            if (s_q == head_q) begin
              head_d = n_q;
            end else begin
              nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = n_q;
            end
            if (s_q == tail_q) begin
              tail_d = p_q;
            end else begin
              prv_we = 1'b1; prv_wa = n_q; prv_wd = p_q;
            end
          end
          pend_d[s_q] = 1'b0;
          out_valid_d = 1'b1;
          out_res_d   = EV_DELETED;
          out_slot_d  = 4'(s_q);
          out_pay_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_R_RD: begin
        if (empty_q) begin
          state_d = S_R_DONE;
        end else begin
          re      = 1'b1;
          raddr   = head_q;
          state_d = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (64'(rel_rd) <= left_q) begin
          if (out_free) begin
            left_d = left_q - 64'(rel_rd);
            if (head_q == tail_q) begin
              empty_d = 1'b1;
            end else begin
              head_d = nxt_rd;
            end
            pend_d[head_q] = 1'b0;
            out_valid_d = 1'b1;
            out_res_d   = EV_EXPIRED;
            out_slot_d  = 4'(head_q);
            out_pay_d   = pay_rd;
            out_last_d  = 1'b0;
            state_d     = S_R_RD;
          end
        end else begin
          rel_we  = 1'b1; rel_wa = head_q; rel_wd = rel_rd - DW'(left_q);
          state_d = S_R_DONE;
        end
      end
      S_R_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = EV_RUN_DONE;
          out_slot_d  = '0;
          out_pay_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      last_run_q  <= '0;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      cur_q       <= '0;
      n_q         <= '0;
      p_q         <= '0;
      d_q         <= '0;
      rel_c_q     <= '0;
      pay_q       <= '0;
      left_q      <= '0;
      resp_q      <= EV_ADDED;
      out_res_q   <= '0;
      out_slot_q  <= '0;
      out_pay_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      last_run_q  <= last_run_d;
      out_valid_q <= out_valid_d;
      s_q         <= s_d;
      cur_q       <= cur_d;
      n_q         <= n_d;
      p_q         <= p_d;
      d_q         <= d_d;
      rel_c_q     <= rel_c_d;
      pay_q       <= pay_d;
      left_q      <= left_d;
      resp_q      <= resp_d;
      out_res_q   <= out_res_d;
      out_slot_q  <= out_slot_d;
      out_pay_q   <= out_pay_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_res_q;
  assign out_slot_o    = out_slot_q;
  assign out_payload_o = out_pay_q;
  assign last_o        = out_last_q;

  dltq_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS)) u_rel_ram (
    .clk_i, .we_i(rel_we), .waddr_i(rel_wa), .wdata_i(rel_wd),
    .re_i(re), .raddr_i(raddr), .rdata_o(rel_rd)
  );

  dltq_ram #(.WIDTH(64), .DEPTH(NUM_SLOTS)) u_pay_ram (
    .clk_i, .we_i(pay_we), .waddr_i(pay_wa), .wdata_i(pay_q),
    .re_i(re), .raddr_i(raddr), .rdata_o(pay_rd)
  );

  dltq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_nxt_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .re_i(re), .raddr_i(raddr), .rdata_o(nxt_rd)
  );

  dltq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prv_ram (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .re_i(re), .raddr_i(raddr), .rdata_o(prv_rd)
  );

  // An empty list has no pending slot.
  a_empty_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (pend_q == '0))
    else $error("empty list with pending slots");

  // Head and tail of a non-empty list are pending slots.
  a_ends_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (pend_q[head_q] && pend_q[tail_q]))
    else $error("list end not pending");

  // Every accepted add, delete or run occupies the block in the next cycle.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i != KIND_NONE) |=> in_stall_o)
    else $error("item accepted without work");

endmodule

>>> dv/delta_list_timer_queue_tb.sv
// Self-checking testbench for the delta-list timer queue with its own list predictor.
`timescale 1ns / 100ps
module delta_list_timer_queue_tb
  import dltq_pkg::*;
();

  localparam int unsigned NSLOT = 16;
  localparam logic [31:0] DMAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [63:0] payload;
    logic [63:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  slot;
    logic [63:0] payload;
    logic        last;
  } evt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [3:0]  slot_i = '0;
  logic [31:0] delay_i = '0;
  logic [63:0] payload_i = '0;
  logic [63:0] now_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [3:0]  out_slot_o;
  logic [63:0] out_payload_o;
  logic        last_o;

  delta_list_timer_queue u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state of the timer list.
  logic [31:0] m_rel [NSLOT];
  logic [63:0] m_pay [NSLOT];
  logic [3:0]  m_next [NSLOT];
  logic [3:0]  m_prev [NSLOT];
  logic        m_pend [NSLOT];
  logic [3:0]  m_head, m_tail;
  logic        m_empty;
  logic [63:0] m_last_run;

  cmd_t cmd_q[$];
  evt_t expected_events[$];
  int   send_idle_pct, recv_idle_pct;
  int   hold_cycles;
  int   mismatches;

  task automatic push_evt(event_e e, logic [3:0] s, logic [63:0] p, logic l);
    evt_t t;
    t.ev = e; t.slot = s; t.payload = p; t.last = l;
    expected_events.push_back(t);
  endtask

  task automatic unlink(logic [3:0] s);
    logic [3:0] p, n;
    p = m_prev[s];
    n = m_next[s];
    if (s == m_head && s == m_tail) m_empty = 1'b1;
    else begin
      if (s == m_head) m_head = n; else m_next[p] = n;
      if (s == m_tail) m_tail = p; else m_prev[n] = p;
    end
    m_pend[s] = 1'b0;
  endtask

  task automatic insert(logic [3:0] s, logic [31:0] d_in);
    logic [31:0] d;
    logic [3:0]  cur, p;
    int steps;
    d = d_in;
    cur = m_head;
    steps = 0;
    if (!m_empty) begin
      while (steps < NSLOT) begin
        if (d <= m_rel[cur]) begin
          p = m_prev[cur];
          m_rel[cur] = m_rel[cur] - d;
          if (cur == m_head) m_head = s; else m_next[p] = s;
          m_prev[s] = p; m_next[s] = cur; m_prev[cur] = s;
          m_rel[s] = d; m_pend[s] = 1'b1;
          return;
        end
        d = d - m_rel[cur];
        if (cur == m_tail) break;
        cur = m_next[cur];
        steps++;
      end
    end
    m_rel[s] = d;
    m_pend[s] = 1'b1;
    if (m_empty) begin
      m_head = s; m_tail = s; m_empty = 1'b0;
    end else begin
      m_next[m_tail] = s; m_prev[s] = m_tail; m_tail = s;
    end
  endtask

  task automatic predict_timer_events(cmd_t c);
    logic [63:0] left;
    logic [32:0] sum;
    logic [3:0]  h, n;
    int k;
    case (kind_e'(c.kind))
      KIND_ADD: begin
        if (m_pend[c.slot]) push_evt(EV_ADD_REJ, c.slot, '0, 1'b1);
        else begin
          m_pay[c.slot] = c.payload;
          insert(c.slot, c.delay);
          push_evt(EV_ADDED, c.slot, '0, 1'b1);
        end
      end
      KIND_DEL: begin
        if (!m_pend[c.slot]) push_evt(EV_NOT_PEND, c.slot, '0, 1'b1);
        else begin
          if (c.slot != m_tail) begin
            n = m_next[c.slot];
            sum = {1'b0, m_rel[n]} + {1'b0, m_rel[c.slot]};
            m_rel[n] = sum[32] ? DMAX : sum[31:0];
          end
          unlink(c.slot);
          push_evt(EV_DELETED, c.slot, '0, 1'b1);
        end
      end
      KIND_RUN: begin
        left = c.now - m_last_run;
        k = 0;
        while (!m_empty && k < NSLOT) begin
          h = m_head;
          if (64'(m_rel[h]) <= left) begin
            left = left - 64'(m_rel[h]);
            unlink(h);
            push_evt(EV_EXPIRED, h, m_pay[h], 1'b0);
            k++;
          end else begin
            m_rel[h] = m_rel[h] - left[31:0];
            break;
          end
        end
        m_last_run = c.now;
        push_evt(EV_RUN_DONE, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Driver: offers queued items, with random gaps between them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_timer_events({kind_i, slot_i, delay_i, payload_i, now_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= c.kind; slot_i <= c.slot; delay_i <= c.delay;
          payload_i <= c.payload; now_i <= c.now;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result ev=%0d slot=%0d pay=%h last=%b",
                     event_res_o, out_slot_o, out_payload_o, last_o);
        end else begin
          evt_t e;
          e = expected_events.pop_front();
          if (e.ev !== event_res_o || e.slot !== out_slot_o ||
              e.payload !== out_payload_o || e.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch exp ev=%0d slot=%0d pay=%h last=%b",
                        " got ev=%0d slot=%0d pay=%h last=%b"},
                       e.ev, e.slot, e.payload, e.last,
                       event_res_o, out_slot_o, out_payload_o, last_o);
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic cmd_t rand_cmd(logic [63:0] base_now);
    cmd_t c;
    int r;
    r = $urandom_range(99);
    c.slot = 4'($urandom_range(15));
    c.payload = {$urandom, $urandom};
    c.delay = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(200));
    c.now = base_now;
    if (r < 50) c.kind = KIND_ADD;
    else if (r < 72) c.kind = KIND_DEL;
    else if (r < 97) c.kind = KIND_RUN;
    else c.kind = KIND_NONE;
    return c;
  endfunction

  task automatic wait_drain();
    while (cmd_q.size() > 0 || in_valid_i || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add_cmd(kind_e k, int s, logic [31:0] d, logic [63:0] p, logic [63:0] t);
    cmd_t c;
    c.kind = k; c.slot = 4'(s); c.delay = d; c.payload = p; c.now = t;
    cmd_q.push_back(c);
  endtask

  initial begin
    logic [63:0] clock_now;
    cmd_t c;
    for (int i = 0; i < NSLOT; i++) begin
      m_pend[i] = 1'b0; m_rel[i] = '0; m_pay[i] = '0; m_next[i] = '0; m_prev[i] = '0;
    end
    m_head = '0; m_tail = '0; m_empty = 1'b1; m_last_run = '0;
    mismatches = 0; hold_cycles = 0;
    send_idle_pct = 14; recv_idle_pct = 50;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, duplicates, ties, backward time, ignored kind.
    add_cmd(KIND_RUN, 0, 0, 0, 64'd0);
    add_cmd(KIND_DEL, 3, 0, 0, 0);
    add_cmd(KIND_ADD, 0, 32'd0, '1, 0);
    add_cmd(KIND_ADD, 15, DMAX, 64'hA5A5_0000_FFFF_1234, 0);
    add_cmd(KIND_ADD, 0, 32'd5, 0, 0);
    add_cmd(KIND_ADD, 5, DMAX, 64'h1, 0);
    add_cmd(KIND_ADD, 6, 32'd10, 64'h2, 0);
    add_cmd(KIND_ADD, 7, 32'd10, 64'h3, 0);
    add_cmd(KIND_DEL, 6, 0, 0, 0);
    add_cmd(KIND_DEL, 15, 0, 0, 0);
    add_cmd(KIND_NONE, 9, 32'h1234, 64'h55, 64'h99);
    add_cmd(KIND_RUN, 0, 0, 0, 64'd4);
    add_cmd(KIND_RUN, 0, 0, 0, 64'd100);
    add_cmd(KIND_RUN, 0, 0, 0, 64'd3);
    add_cmd(KIND_RUN, 0, 0, 0, '1);
    add_cmd(KIND_ADD, 1, 32'd1, 64'h0, 0);
    add_cmd(KIND_RUN, 0, 0, 0, 64'd0);
    add_cmd(KIND_RUN, 0, 0, 0, 64'd0);
    clock_now = 64'd0;
    wait_drain();

    // Random phases; each round mixes random adds, deletes, runs and ignored items, then drains.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 14 : 0;
      for (int i = 0; i < 137; i++) begin
        c = rand_cmd(clock_now);
        if (c.kind == KIND_RUN) begin
          clock_now = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                               : clock_now + $urandom_range(300);
          c.now = clock_now;
        end
        cmd_q.push_back(c);
      end
      if (ph == 1) begin
        @(posedge clk_i);
        hold_cycles <= 400;
      end
      wait_drain();
    end
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/dltq_pkg.sv
rtl/core/dltq_ram.sv
rtl/core/delta_list_timer_queue.sv
dv/delta_list_timer_queue_tb.sv
